>>> design/thsp_pkg.sv
// ----------------------------------------------------------------------------
// thsp_pkg
// Shared types and constants for the tar header stream parser.
// ----------------------------------------------------------------------------
package thsp_pkg;

    localparam int unsigned OFF_W        = 9;
    localparam int unsigned SUM_W        = 17;
    localparam int unsigned SIZE_W       = 33;
    localparam int unsigned MODE_W       = 21;
    localparam int unsigned MTIME_W      = 33;
    localparam int unsigned CHK_W        = 21;
    localparam int unsigned SKIP_W       = 24;
    localparam int unsigned BLOCK_SHIFT  = 9;

    localparam logic [OFF_W-1:0] OFF_FIRST      = 9'd0;
    localparam logic [OFF_W-1:0] OFF_MODE_LO    = 9'd100;
    localparam logic [OFF_W-1:0] OFF_MODE_HI    = 9'd107;
    localparam logic [OFF_W-1:0] OFF_SIZE_LO    = 9'd124;
    localparam logic [OFF_W-1:0] OFF_SIZE_HI    = 9'd134;
    localparam logic [OFF_W-1:0] OFF_MTIME_LO   = 9'd136;
    localparam logic [OFF_W-1:0] OFF_MTIME_HI   = 9'd147;
    localparam logic [OFF_W-1:0] OFF_CHK_LO     = 9'd148;
    localparam logic [OFF_W-1:0] OFF_CHK_HI     = 9'd155;
    localparam logic [OFF_W-1:0] OFF_TYPE       = 9'd156;
    localparam logic [OFF_W-1:0] OFF_MAGIC_LO   = 9'd257;
    localparam logic [OFF_W-1:0] OFF_MAGIC_HI   = 9'd261;
    localparam logic [OFF_W-1:0] OFF_LAST       = 9'd511;

    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_TILDE  = 8'h7E;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_SEVEN  = 8'h37;

    typedef struct packed {
        logic clr;
        logic en;
    } t_oct_ctl;

    function automatic logic [7:0] magic_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h75;
            3'd1:    c = 8'h73;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h61;
            3'd4:    c = 8'h72;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

>>> design/thsp_octal_acc.sv
// ----------------------------------------------------------------------------
// thsp_octal_acc
// Octal text field accumulator: shifts in digits until the first non-digit.
// ----------------------------------------------------------------------------
module thsp_octal_acc #(
    parameter int unsigned W = 21
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  thsp_pkg::t_oct_ctl i_ctl,
    input  logic [7:0]         i_byte,
    output logic [W-1:0]       o_value
);

    logic [W-1:0] r_acc, n_acc;
    logic         r_stop, n_stop;
    logic         digit;

    assign digit = (i_byte >= thsp_pkg::CHAR_ZERO) && (i_byte <= thsp_pkg::CHAR_SEVEN);

    always_comb begin
        n_acc  = r_acc;
        n_stop = r_stop;
        if (i_ctl.clr) begin
            n_acc  = '0;
            n_stop = 1'b0;
        end else if (i_ctl.en && !r_stop) begin
            if (digit) begin
                n_acc = {r_acc[W-4:0], i_byte[2:0]};
            end else begin
                n_stop = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_stop <= 1'b0;
        end else begin
            r_acc  <= n_acc;
            r_stop <= n_stop;
        end
    end

    assign o_value = r_acc;

endmodule

>>> design/tar_header_stream_parser_unit.sv
// ----------------------------------------------------------------------------
// tar_header_stream_parser_unit
// Streaming ustar header parser: one archive byte per beat, one record per
// named header block, data blocks skipped.
// ----------------------------------------------------------------------------
// Each byte beat is taken into an input register and handled from there by
// one pass of add, shift and compare logic, so one byte is accepted every
// cycle while no record waits; a record is loaded into the output register
// as the header's last byte is handled. Only that last byte waits when the
// output register still holds an untaken record.
module tar_header_stream_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [32:0] o_entry_size,
    output logic [20:0] o_entry_mode,
    output logic [32:0] o_entry_mtime,
    output logic [7:0]  o_entry_type,
    output logic        o_checksum_ok,
    output logic        o_magic_ok
);

    logic                          r_in_valid;
    logic [7:0]                    r_in_byte;
    logic [thsp_pkg::OFF_W-1:0]    r_offset;
    logic                          r_in_data, n_in_data;
    logic [thsp_pkg::SKIP_W-1:0]   r_blocks, n_blocks;
    logic [thsp_pkg::SUM_W-1:0]    r_sum, n_sum;
    logic                          r_magic, n_magic;
    logic                          r_name_empty, n_name_empty;
    logic [7:0]                    r_type, n_type;

    logic                          r_out_valid;
    logic [32:0]                   r_size_o;
    logic [20:0]                   r_mode_o;
    logic [32:0]                   r_mtime_o;
    logic [7:0]                    r_type_o;
    logic                          r_chk_o;
    logic                          r_magic_o;

    logic                          hdr, emit, out_free, fire, first;
    logic                          in_chk;
    logic [thsp_pkg::OFF_W-1:0]    magic_idx;
    logic [thsp_pkg::SIZE_W-1:0]   size_m1;

    thsp_pkg::t_oct_ctl            mode_ctl, size_ctl, mtime_ctl, chk_ctl;
    logic [thsp_pkg::MODE_W-1:0]   mode_val;
    logic [thsp_pkg::SIZE_W-1:0]   size_val;
    logic [thsp_pkg::MTIME_W-1:0]  mtime_val;
    logic [thsp_pkg::CHK_W-1:0]    chk_val;

    assign hdr      = r_in_valid && !r_in_data;
    assign first    = r_offset == thsp_pkg::OFF_FIRST;
    assign emit     = hdr && (r_offset == thsp_pkg::OFF_LAST) && !r_name_empty;
    assign out_free = !r_out_valid || i_out_ready;
    assign fire     = r_in_valid && (!emit || out_free);
    assign o_in_ready = !r_in_valid || fire;

    assign in_chk    = (r_offset >= thsp_pkg::OFF_CHK_LO) && (r_offset <= thsp_pkg::OFF_CHK_HI);
    assign magic_idx = r_offset - thsp_pkg::OFF_MAGIC_LO;
    assign size_m1   = size_val - 33'd1;

    always_comb begin
        mode_ctl.clr  = fire && hdr && first;
        size_ctl.clr  = mode_ctl.clr;
        mtime_ctl.clr = mode_ctl.clr;
        chk_ctl.clr   = mode_ctl.clr;
        mode_ctl.en   = fire && hdr && (r_offset >= thsp_pkg::OFF_MODE_LO)
                        && (r_offset <= thsp_pkg::OFF_MODE_HI);
        size_ctl.en   = fire && hdr && (r_offset >= thsp_pkg::OFF_SIZE_LO)
                        && (r_offset <= thsp_pkg::OFF_SIZE_HI);
        mtime_ctl.en  = fire && hdr && (r_offset >= thsp_pkg::OFF_MTIME_LO)
                        && (r_offset <= thsp_pkg::OFF_MTIME_HI);
        chk_ctl.en    = fire && hdr && in_chk;
    end

    thsp_octal_acc #(.W(thsp_pkg::MODE_W)) u_mode (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(mode_ctl),
        .i_byte(r_in_byte), .o_value(mode_val)
    );

    thsp_octal_acc #(.W(thsp_pkg::SIZE_W)) u_size (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(size_ctl),
        .i_byte(r_in_byte), .o_value(size_val)
    );

    thsp_octal_acc #(.W(thsp_pkg::MTIME_W)) u_mtime (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(mtime_ctl),
        .i_byte(r_in_byte), .o_value(mtime_val)
    );

    thsp_octal_acc #(.W(thsp_pkg::CHK_W)) u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(chk_ctl),
        .i_byte(r_in_byte), .o_value(chk_val)
    );

    always_comb begin
        n_in_data    = r_in_data;
        n_blocks     = r_blocks;
        n_sum        = r_sum;
        n_magic      = r_magic;
        n_name_empty = r_name_empty;
        n_type       = r_type;
        if (r_in_data) begin
            if (r_offset == thsp_pkg::OFF_LAST) begin
                if (r_blocks == '0) begin
                    n_in_data = 1'b0;
                end else begin
                    n_blocks = r_blocks - 24'd1;
                end
            end
        end else begin
            if (first) begin
                n_sum        = '0;
                n_magic      = 1'b1;
                n_type       = 8'h00;
                n_name_empty = !((r_in_byte >= thsp_pkg::CHAR_SPACE)
                                 && (r_in_byte <= thsp_pkg::CHAR_TILDE));
            end
            n_sum = n_sum + {9'd0, (in_chk ? thsp_pkg::CHAR_SPACE : r_in_byte)};
            if (r_offset == thsp_pkg::OFF_TYPE) begin
                n_type = r_in_byte;
            end
            if ((r_offset >= thsp_pkg::OFF_MAGIC_LO) && (r_offset <= thsp_pkg::OFF_MAGIC_HI)
                && (r_in_byte != thsp_pkg::magic_char(magic_idx[2:0]))) begin
                n_magic = 1'b0;
            end
            if (emit) begin
                if (size_val == '0) begin
                    n_in_data = 1'b0;
                    n_blocks  = '0;
                end else begin
                    n_in_data = 1'b1;
                    n_blocks  = size_m1[thsp_pkg::SIZE_W-1:thsp_pkg::BLOCK_SHIFT];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_offset     <= '0;
            r_in_data    <= 1'b0;
            r_blocks     <= '0;
            r_sum        <= '0;
            r_magic      <= 1'b1;
            r_name_empty <= 1'b0;
            r_type       <= 8'h00;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (fire) begin
                r_offset     <= r_offset + 9'd1;
                r_in_data    <= n_in_data;
                r_blocks     <= n_blocks;
                r_sum        <= n_sum;
                r_magic      <= n_magic;
                r_name_empty <= n_name_empty;
                r_type       <= n_type;
            end
            if (fire && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
        end
        if (fire && emit) begin
            r_size_o  <= size_val;
            r_mode_o  <= mode_val;
            r_mtime_o <= mtime_val;
            r_type_o  <= n_type;
            r_chk_o   <= chk_val == {4'd0, n_sum};
            r_magic_o <= n_magic;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_entry_size  = r_size_o;
    assign o_entry_mode  = r_mode_o;
    assign o_entry_mtime = r_mtime_o;
    assign o_entry_type  = r_type_o;
    assign o_checksum_ok = r_chk_o;
    assign o_magic_ok    = r_magic_o;

endmodule
